@@ design/acm_pkg.sv @@
// ----------------------------------------------------------------------------
// acm_pkg
// shared types and fixed field widths of the multi-pattern string matcher
// ----------------------------------------------------------------------------
package acm_pkg;

    localparam int OP_W     = 3;
    localparam int LETTER_W = 5;
    localparam int WIDX_W   = 4;
    localparam int MINW_W   = 5;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 3'd0,
        OP_PATTERN = 3'd1,
        OP_BUILD   = 3'd2,
        OP_RESTART = 3'd3,
        OP_TEXT    = 3'd4
    } t_op;

endpackage

@@ design/acm_ram.sv @@
// ----------------------------------------------------------------------------
// acm_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module acm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/acm_popcnt.sv @@
// ----------------------------------------------------------------------------
// acm_popcnt
// counts the words in a word set and compares against a threshold
// ----------------------------------------------------------------------------
module acm_popcnt #(
    parameter int WORDS = 16
) (
    input  logic [WORDS-1:0]              i_mask,
    input  logic [acm_pkg::MINW_W-1:0]    i_min,
    output logic                          o_enough
);

    localparam int CW = $clog2(WORDS + 1);

    logic [CW-1:0] cnt;

    always_comb begin
        cnt = '0;
        for (int i = 0; i < WORDS; i++) begin
            cnt = cnt + CW'(i_mask[i]);
        end
    end

    assign o_enough = (32'(cnt) >= 32'(i_min));

endmodule

@@ design/multi_pattern_string_matcher.sv @@
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher
// aho-corasick matcher: trie build, failure link build and text scan
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low, and gives exactly
// one result, shown for one cycle with o_result_valid; the receiver cannot
// stall it. Restart, unused ops and out-of-range letters answer straight from
// idle. A pattern letter reads the child table, and the node table too when it
// tags an existing node. A text letter follows failure links, with a child
// table and node table read for each step. A build reads the child table entry
// of every letter of every reached node, takes each node from the queue, links
// children of the root to the root, finds every other new link by a failure
// walk and then finishes. Clear answers at once, then busy stays high for the
// clearing pass over the NODES*LETTERS (6656 by default) child table entries;
// the same pass runs after reset. Configuration is taken any time.
module multi_pattern_string_matcher #(
    parameter int NODES   = 256,
    parameter int WORDS   = 16,
    parameter int LETTERS = 26
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [acm_pkg::OP_W-1:0]     i_op,
    input  logic [acm_pkg::LETTER_W-1:0] i_letter,
    input  logic                         i_word_end,
    input  logic [acm_pkg::WIDX_W-1:0]   i_word_index,
    input  logic                         i_cfg_we,
    input  logic [acm_pkg::MINW_W-1:0]   i_cfg_wdata,
    output logic                         o_result_valid,
    output logic [$clog2(NODES)-1:0]     o_automaton_state,
    output logic [WORDS-1:0]             o_match_mask,
    output logic [WORDS-1:0]             o_seen_mask,
    output logic                         o_enough_words,
    output logic                         o_status
);

    // widths
    localparam int NW     = $clog2(NODES);
    localparam int NCW    = $clog2(NODES + 1);
    localparam int LTW    = (LETTERS > 1) ? $clog2(LETTERS) : 1;
    localparam int CDEPTH = NODES * LETTERS;
    localparam int CAW    = $clog2(CDEPTH);
    localparam int NMW    = NW + WORDS;
    localparam logic [NW-1:0] ROOT = NW'(1);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_P_KID, S_P_WS,
        S_A_RD, S_A_CHK, S_A_FAIL, S_T_WS,
        S_B_KID_RD, S_B_KID, S_B_F, S_B_W,
        S_B_DQ, S_B_DQ_Q, S_B_DQ_F
    } t_state;

    t_state r_state, n_state;

    // control and scan registers
    logic [CAW-1:0]              r_cnt, n_cnt;
    logic [NCW-1:0]              r_count, n_count;
    logic [NW-1:0]               r_cursor, n_cursor;
    logic [NW-1:0]               r_scan, n_scan;
    logic [WORDS-1:0]            r_seen, n_seen;
    logic [acm_pkg::MINW_W-1:0]  r_min, n_min;
    // latched transaction
    logic [acm_pkg::LETTER_W-1:0] r_letter, n_letter;
    logic                        r_wend, n_wend;
    logic [acm_pkg::WIDX_W-1:0]  r_widx, n_widx;
    // walk and build working registers
    logic [NW-1:0]               r_p, n_p;
    logic                        r_is_build, n_is_build;
    logic                        r_phase0, n_phase0;
    logic [LTW-1:0]              r_a, n_a;
    logic [NW-1:0]               r_q, n_q;
    logic [NW-1:0]               r_qfail, n_qfail;
    logic [NW-1:0]               r_r, n_r;
    logic [NW-1:0]               r_f, n_f;
    logic [NW-1:0]               r_c, n_c;
    logic [WORDS-1:0]            r_wsf, n_wsf;
    logic [NCW-1:0]              r_head, n_head;
    logic [NCW-1:0]              r_tail, n_tail;
    // result registers
    logic                        r_valid, n_valid;
    logic [WORDS-1:0]            r_match, n_match;
    logic                        r_status, n_status;

    // memory ports
    logic            ch_we;
    logic [CAW-1:0]  ch_waddr, ch_raddr;
    logic [NW-1:0]   ch_wdata, ch_rdata;
    logic            nm_we;
    logic [NW-1:0]   nm_waddr, nm_raddr;
    logic [NMW-1:0]  nm_wdata, nm_rdata;
    logic            q_we;
    logic [NW-1:0]   q_waddr, q_raddr;
    logic [NW-1:0]   q_wdata, q_rdata;

    logic [NW-1:0]    nm_fail;
    logic [WORDS-1:0] nm_ws;
    logic [WORDS-1:0] word_bit;
    logic             widx_ok;
    logic [LTW-1:0]   adv_a;

    assign nm_fail  = nm_rdata[NMW-1 -: NW];
    assign nm_ws    = nm_rdata[WORDS-1:0];
    assign word_bit = WORDS'(1) << r_widx;
    assign widx_ok  = (32'(r_widx) < WORDS);
    assign adv_a    = r_is_build ? r_a : LTW'(r_letter);

    function automatic logic [CAW-1:0] child_addr(input logic [NW-1:0] q,
                                                 input logic [LTW-1:0] a);
        child_addr = CAW'(q) * CAW'(LETTERS) + CAW'(a);
    endfunction

    // child table: node x letter -> child node, zero for none
    acm_ram #(.WIDTH(NW), .DEPTH(CDEPTH)) u_child (
        .i_clk(i_clk), .i_we(ch_we), .i_waddr(ch_waddr), .i_wdata(ch_wdata),
        .i_raddr(ch_raddr), .o_rdata(ch_rdata)
    );

    // node table: failure link and word set of each node
    acm_ram #(.WIDTH(NMW), .DEPTH(NODES)) u_node (
        .i_clk(i_clk), .i_we(nm_we), .i_waddr(nm_waddr), .i_wdata(nm_wdata),
        .i_raddr(nm_raddr), .o_rdata(nm_rdata)
    );

    // breadth-first queue of the link build
    acm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    acm_popcnt #(.WORDS(WORDS)) u_popcnt (
        .i_mask(r_seen), .i_min(r_min), .o_enough(o_enough_words)
    );

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_count    = r_count;
        n_cursor   = r_cursor;
        n_scan     = r_scan;
        n_seen     = r_seen;
        n_min      = r_min;
        n_letter   = r_letter;
        n_wend     = r_wend;
        n_widx     = r_widx;
        n_p        = r_p;
        n_is_build = r_is_build;
        n_phase0   = r_phase0;
        n_a        = r_a;
        n_q        = r_q;
        n_qfail    = r_qfail;
        n_r        = r_r;
        n_f        = r_f;
        n_c        = r_c;
        n_wsf      = r_wsf;
        n_head     = r_head;
        n_tail     = r_tail;
        n_valid    = 1'b0;
        n_match    = r_match;
        n_status   = r_status;
        ch_we      = 1'b0;
        ch_waddr   = '0;
        ch_wdata   = '0;
        ch_raddr   = '0;
        nm_we      = 1'b0;
        nm_waddr   = '0;
        nm_wdata   = '0;
        nm_raddr   = '0;
        q_we       = 1'b0;
        q_waddr    = '0;
        q_wdata    = '0;
        q_raddr    = '0;

        if (i_cfg_we) begin
            n_min = i_cfg_wdata;
        end

        case (r_state)
            S_CLR: begin
                // sweep the child table, node table rides along for its depth
                ch_we    = 1'b1;
                ch_waddr = r_cnt;
                if (32'(r_cnt) < NODES) begin
                    nm_we    = 1'b1;
                    nm_waddr = NW'(r_cnt);
                    nm_wdata = {ROOT, {WORDS{1'b0}}};
                end
                if (32'(r_cnt) == CDEPTH - 1) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + CAW'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_letter = i_letter;
                    n_wend   = i_word_end;
                    n_widx   = i_word_index;
                    n_match  = '0;
                    n_status = 1'b0;
                    case (acm_pkg::t_op'(i_op))
                        acm_pkg::OP_CLEAR: begin
                            n_count  = NCW'(2);
                            n_cursor = ROOT;
                            n_scan   = ROOT;
                            n_seen   = '0;
                            n_cnt    = '0;
                            n_valid  = 1'b1;
                            n_state  = S_CLR;
                        end
                        acm_pkg::OP_PATTERN: begin
                            if (32'(i_letter) < LETTERS) begin
                                ch_raddr = child_addr(r_cursor, LTW'(i_letter));
                                n_state  = S_P_KID;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        acm_pkg::OP_BUILD: begin
                            n_q        = ROOT;
                            n_phase0   = 1'b1;
                            n_a        = '0;
                            n_head     = '0;
                            n_tail     = '0;
                            n_is_build = 1'b1;
                            n_state    = S_B_KID_RD;
                        end
                        acm_pkg::OP_RESTART: begin
                            n_scan  = ROOT;
                            n_seen  = '0;
                            n_valid = 1'b1;
                        end
                        acm_pkg::OP_TEXT: begin
                            if (32'(i_letter) < LETTERS) begin
                                n_p        = r_scan;
                                n_is_build = 1'b0;
                                n_state    = S_A_RD;
                            end else begin
                                // no child anywhere, scan falls back to root
                                n_scan  = ROOT;
                                n_valid = 1'b1;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_P_KID: begin
                if (ch_rdata == '0) begin
                    if (32'(r_count) >= NODES) begin
                        n_status = 1'b1;
                    end else begin
                        ch_we    = 1'b1;
                        ch_waddr = child_addr(r_cursor, LTW'(r_letter));
                        ch_wdata = NW'(r_count);
                        nm_we    = 1'b1;
                        nm_waddr = NW'(r_count);
                        nm_wdata = {ROOT, (r_wend && widx_ok) ? word_bit : {WORDS{1'b0}}};
                        n_count  = r_count + NCW'(1);
                        n_cursor = r_wend ? ROOT : NW'(r_count);
                    end
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (r_wend) begin
                    n_cursor = ROOT;
                    if (widx_ok) begin
                        nm_raddr = ch_rdata;
                        n_c      = ch_rdata;
                        n_state  = S_P_WS;
                    end else begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_cursor = ch_rdata;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_P_WS: begin
                nm_we    = 1'b1;
                nm_waddr = r_c;
                nm_wdata = {nm_fail, nm_ws | word_bit};
                n_valid  = 1'b1;
                n_state  = S_IDLE;
            end
            S_A_RD: begin
                ch_raddr = child_addr(r_p, adv_a);
                n_state  = S_A_CHK;
            end
            S_A_CHK: begin
                if (ch_rdata != '0 || r_p == ROOT) begin
                    if (r_is_build) begin
                        n_f      = (ch_rdata != '0) ? ch_rdata : ROOT;
                        nm_raddr = (ch_rdata != '0) ? ch_rdata : ROOT;
                        n_state  = S_B_F;
                    end else begin
                        n_scan   = (ch_rdata != '0) ? ch_rdata : ROOT;
                        nm_raddr = (ch_rdata != '0) ? ch_rdata : ROOT;
                        n_state  = S_T_WS;
                    end
                end else begin
                    nm_raddr = r_p;
                    n_state  = S_A_FAIL;
                end
            end
            S_A_FAIL: begin
                n_p     = nm_fail;
                n_state = S_A_RD;
            end
            S_T_WS: begin
                n_match = nm_ws;
                n_seen  = r_seen | nm_ws;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_B_KID_RD: begin
                ch_raddr = child_addr(r_q, r_a);
                n_state  = S_B_KID;
            end
            S_B_KID: begin
                if (ch_rdata != '0 && 32'(r_tail) < NODES) begin
                    n_r = ch_rdata;
                    if (r_phase0) begin
                        n_f      = ROOT;
                        nm_raddr = ROOT;
                        n_state  = S_B_F;
                    end else begin
                        n_p     = r_qfail;
                        n_state = S_A_RD;
                    end
                end else if (32'(r_a) == LETTERS - 1) begin
                    n_phase0 = 1'b0;
                    n_state  = S_B_DQ;
                end else begin
                    n_a     = r_a + LTW'(1);
                    n_state = S_B_KID_RD;
                end
            end
            S_B_F: begin
                // word set of the failure node here, child node read next
                n_wsf    = nm_ws;
                nm_raddr = r_r;
                n_state  = S_B_W;
            end
            S_B_W: begin
                nm_we    = 1'b1;
                nm_waddr = r_r;
                nm_wdata = {r_f, nm_ws | r_wsf};
                q_we     = 1'b1;
                q_waddr  = NW'(r_tail);
                q_wdata  = r_r;
                n_tail   = r_tail + NCW'(1);
                if (32'(r_a) == LETTERS - 1) begin
                    n_phase0 = 1'b0;
                    n_state  = S_B_DQ;
                end else begin
                    n_a     = r_a + LTW'(1);
                    n_state = S_B_KID_RD;
                end
            end
            S_B_DQ: begin
                if (r_head < r_tail) begin
                    q_raddr = NW'(r_head);
                    n_head  = r_head + NCW'(1);
                    n_state = S_B_DQ_Q;
                end else begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_B_DQ_Q: begin
                n_q      = q_rdata;
                nm_raddr = q_rdata;
                n_state  = S_B_DQ_F;
            end
            S_B_DQ_F: begin
                n_qfail = nm_fail;
                n_a     = '0;
                n_state = S_B_KID_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cnt    <= '0;
            r_count  <= NCW'(2);
            r_cursor <= ROOT;
            r_scan   <= ROOT;
            r_seen   <= '0;
            r_min    <= '0;
            r_valid  <= 1'b0;
            r_match  <= '0;
            r_status <= 1'b0;
            r_phase0 <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_scan   <= n_scan;
            r_seen   <= n_seen;
            r_min    <= n_min;
            r_valid  <= n_valid;
            r_match  <= n_match;
            r_status <= n_status;
            r_phase0 <= n_phase0;
            r_head   <= n_head;
            r_tail   <= n_tail;
        end
        r_letter   <= n_letter;
        r_wend     <= n_wend;
        r_widx     <= n_widx;
        r_p        <= n_p;
        r_is_build <= n_is_build;
        r_a        <= n_a;
        r_q        <= n_q;
        r_qfail    <= n_qfail;
        r_r        <= n_r;
        r_f        <= n_f;
        r_c        <= n_c;
        r_wsf      <= n_wsf;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_result_valid    = r_valid;
    assign o_automaton_state = r_scan;
    assign o_match_mask      = r_match;
    assign o_seen_mask       = r_seen;
    assign o_status          = r_status;

`ifndef SYNTHESIS
    // clear answers at once and then runs its clearing pass
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == acm_pkg::OP_CLEAR) |=> (o_result_valid && busy))
        else $error("clear transaction without result or clearing pass");

    // restart empties the seen set and returns to root
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == acm_pkg::OP_RESTART)
        |=> (o_result_valid && o_seen_mask == '0 && o_automaton_state == ROOT))
        else $error("restart did not reset the scan");

    // a dropped letter only happens with a full node store
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status) |-> (32'(r_count) == NODES))
        else $error("letter dropped with room in the node store");

    // the build queue never overruns the node store
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head <= r_tail) && (32'(r_tail) <= NODES))
        else $error("build queue pointers out of range");
`endif

endmodule
